// File: rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

  // Operation codes carried in the input tuser field; codes 6 and 7 act as a query.
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REVERSE    = 3'd4,
    ACT_QUERY      = 3'd5
  } dq_action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } dq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_RESP = 2'd2
  } dq_state_e;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned ActionW = 3;
  localparam int unsigned StatusW = 2;

endpackage

// File: rtl/double_ended_queue_top.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of 64-bit words with one result per operation.
// Input channel: s_axis_tuser carries the operation (push front, push back,
// pop front, pop back, reverse, query) and s_axis_tdata the word to push.
// Output channel: m_axis_tdata carries the front and back words, the count,
// an empty flag and a status (ok, empty on pop or reverse, full on push).
// In turn, the accept cycle updates the indices and writes the pushed word,
// the next cycle reads the head and tail entries from the two-read-port element
// RAM, and the response state loads the result into the output register; a new
// transaction is taken only after the block returns to idle.
// The output register lets the next transaction enter while a result waits;
// if the receiver still stalls when that next result is ready, the block
// holds in its response state and keeps re-reading the same entries.
// Reset empties the queue and clears the direction flag at once; the RAM is
// not cleared, since the words read are used only while the queue holds entries.
// A reverse flips the direction flag and moves no entries.

module double_ended_queue_top #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: action (3).
  input  logic [7:0]             s_axis_tuser,
  // Fields from bit 0: value (64).
  input  logic [63:0]            s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0: front_value (64), back_value (64), count ($clog2(DEPTH+1)),
  // is_empty (1), status (2), zero padding to whole bytes.
  output logic [((128 + $clog2(DEPTH + 1) + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  import dq_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned OutW = ((128 + CntW + 3 + 7) / 8) * 8;
  localparam int unsigned RawW = 2 * ValueW + CntW + 1 + StatusW;

  localparam logic [CntW:0]   DepthS   = (CntW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC   = CntW'(DEPTH);
  localparam logic [AW-1:0]   LastIdx  = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CntW-1:0] off);
    logic [CntW:0] sum;
    begin
      sum = (CntW + 1)'(base) + (CntW + 1)'(off);
      if (sum >= DepthS) begin
        sum = sum - DepthS;
      end
      return sum[AW-1:0];
    end
  endfunction

  dq_state_e        state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             rev_q, rev_d;
  dq_status_e       status_q, status_d;

  logic             out_valid_q;
  logic [OutW-1:0]  out_data_q;
  logic             out_load;

  logic             accept;
  logic [2:0]       action;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    tail_idx;
  logic [ValueW-1:0] rd_head, rd_tail;
  logic [ValueW-1:0] front_val, back_val;
  logic             is_empty;

  assign action   = s_axis_tuser[ActionW-1:0];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign tail_idx = ring_add(head_q, count_q - CntW'(1));
  assign is_empty = (count_q == '0);

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    rev_d         = rev_q;
    status_d      = status_q;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = head_q;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d  = ST_READ;
          status_d = STAT_OK;
          case (action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              if (count_q == DepthC) begin
                status_d = STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
                // Front push in normal order, or back push when reversed, goes at the head.
                if ((action == ACT_PUSH_FRONT) != rev_q) begin
                  head_d    = (head_q == '0) ? LastIdx : head_q - AW'(1);
                  ram_waddr = head_d;
                end else begin
                  ram_waddr = ring_add(head_q, count_q);
                end
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (is_empty) begin
                status_d = STAT_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
                if ((action == ACT_POP_FRONT) != rev_q) begin
                  head_d = (head_q == LastIdx) ? '0 : head_q + AW'(1);
                end
              end
            end
            ACT_REVERSE: begin
              if (is_empty) begin
                status_d = STAT_EMPTY;
              end else begin
                rev_d = !rev_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  dq_ram #(
    .WIDTH(ValueW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (s_axis_tdata),
    .raddr_a_i(head_q),
    .raddr_b_i(tail_idx),
    .rdata_a_o(rd_head),
    .rdata_b_o(rd_tail)
  );

  always_comb begin
    front_val = '0;
    back_val  = '0;
    if (!is_empty) begin
      front_val = rev_q ? rd_tail : rd_head;
      back_val  = rev_q ? rd_head : rd_tail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      rev_q    <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      rev_q    <= rev_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OutW'(RawW'({status_q, is_empty, count_q, back_val, front_val}));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("deque count above depth");

  a_accept_to_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_READ)
    else $error("accepted transaction did not start the read");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK) && count_q != DepthC
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("successful push did not grow the count");

  a_rev_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action == ACT_REVERSE && is_empty |=> $stable(rev_q))
    else $error("reverse on empty deque changed the direction");

  a_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> accept && state_q == ST_IDLE)
    else $error("element store written outside an accepted transaction");

endmodule

// File: rtl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
